FILE: src/tte_pkg.sv
// Package for the three-tap echo mixer: register codes, reset values,
// field widths and default sizes. No dependencies.
package tte_pkg;

  localparam int unsigned SMP_W    = 8;
  localparam int unsigned DLY_W    = 16;
  localparam int unsigned GAIN_W   = 9;
  localparam int unsigned SEEN_W   = 17;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned NUM_TAPS = 3;

  localparam int unsigned HISTORY_DEPTH_DEF      = 65536;
  localparam int unsigned GAIN_FRACTION_BITS_DEF = 8;

  localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(65536);
  localparam logic [SMP_W-1:0]  SMP_MID    = SMP_W'(128);

  localparam logic [DLY_W-1:0]  DELAY_ONE_RST   = DLY_W'(14666);
  localparam logic [DLY_W-1:0]  DELAY_TWO_RST   = DLY_W'(22000);
  localparam logic [DLY_W-1:0]  DELAY_THREE_RST = DLY_W'(34000);
  localparam logic [GAIN_W-1:0] GAIN_ONE_RST    = GAIN_W'(128);
  localparam logic [GAIN_W-1:0] GAIN_TWO_RST    = GAIN_W'(102);
  localparam logic [GAIN_W-1:0] GAIN_THREE_RST  = GAIN_W'(77);

  typedef enum logic [2:0] {
    REG_DELAY_ONE   = 3'd0,
    REG_DELAY_TWO   = 3'd1,
    REG_DELAY_THREE = 3'd2,
    REG_GAIN_ONE    = 3'd3,
    REG_GAIN_TWO    = 3'd4,
    REG_GAIN_THREE  = 3'd5
  } reg_index_t;

endpackage

FILE: src/three_tap_echo_mixer.sv
// Three-tap echo mixer, top level. Uses tte_pkg and tte_ram.
// Pipeline: eleven register stages (history read, tap multiply, sum, then
// eight compare/subtract divide stages).
// Throughput: one item per cycle while the output is not held; the divider is
// fully pipelined, one quotient bit per stage, and each tap has its own history RAM read port.
// Reset (synchronous): empties the pipeline, clears the write slot and sample
// count, and loads the default delays and gains. History RAM is not cleared.
module three_tap_echo_mixer #(
  parameter int unsigned HISTORY_DEPTH      = tte_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned GAIN_FRACTION_BITS = tte_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tte_pkg::SMP_W-1:0]   sample_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tte_pkg::SMP_W-1:0]   sample_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tte_pkg::PADDR_W-1:0] paddr,
  input  logic [tte_pkg::PDATA_W-1:0] pwdata,
  output logic [tte_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import tte_pkg::*;

  // HISTORY_DEPTH is a power of two
  localparam int unsigned AW      = $clog2(HISTORY_DEPTH);
  localparam int unsigned UNITY   = 1 << GAIN_FRACTION_BITS;
  localparam int unsigned DEN_MSB = (GAIN_FRACTION_BITS > 11) ? GAIN_FRACTION_BITS : 11;
  localparam int unsigned DEN_W   = DEN_MSB + 1;
  localparam int unsigned NUM_W   = DEN_W + SMP_W;
  localparam int unsigned PROD_W  = SMP_W + GAIN_W;
  localparam int unsigned Q_W     = SMP_W;
  localparam int unsigned NST     = 3 + Q_W;

  // configuration
  logic [DLY_W-1:0]  delay_reg [NUM_TAPS];
  logic [GAIN_W-1:0] gain_reg  [NUM_TAPS];
  logic [DEN_W-1:0]  den_reg;
  logic              cfg_wr;
  reg_index_t        cfg_idx;

  // pipeline control
  logic [NST:1] vld;
  logic [NST:1] ld;
  logic         acc;

  // ring bookkeeping
  logic [AW-1:0]     write_index;
  logic [SEEN_W-1:0] samples_seen;

  // stage data
  logic [SMP_W-1:0]  rd_data [NUM_TAPS];
  logic [SMP_W-1:0]  s1_cur;
  logic [NUM_TAPS-1:0] s1_act;
  logic [NUM_TAPS-1:0] s1_byp;
  logic [SMP_W-1:0]  s2_cur;
  logic [PROD_W-1:0] s2_prod [NUM_TAPS];
  logic [NUM_W-1:0]  dv_rem [0:Q_W-1];
  logic [Q_W-1:0]    dv_q   [1:Q_W];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_reg[0] <= DELAY_ONE_RST;
      delay_reg[1] <= DELAY_TWO_RST;
      delay_reg[2] <= DELAY_THREE_RST;
      gain_reg[0]  <= GAIN_ONE_RST;
      gain_reg[1]  <= GAIN_TWO_RST;
      gain_reg[2]  <= GAIN_THREE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DELAY_ONE:   delay_reg[0] <= pwdata[DLY_W-1:0];
        REG_DELAY_TWO:   delay_reg[1] <= pwdata[DLY_W-1:0];
        REG_DELAY_THREE: delay_reg[2] <= pwdata[DLY_W-1:0];
        REG_GAIN_ONE:    gain_reg[0]  <= pwdata[GAIN_W-1:0];
        REG_GAIN_TWO:    gain_reg[1]  <= pwdata[GAIN_W-1:0];
        REG_GAIN_THREE:  gain_reg[2]  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DELAY_ONE:   prdata = PDATA_W'(delay_reg[0]);
      REG_DELAY_TWO:   prdata = PDATA_W'(delay_reg[1]);
      REG_DELAY_THREE: prdata = PDATA_W'(delay_reg[2]);
      REG_GAIN_ONE:    prdata = PDATA_W'(gain_reg[0]);
      REG_GAIN_TWO:    prdata = PDATA_W'(gain_reg[1]);
      REG_GAIN_THREE:  prdata = PDATA_W'(gain_reg[2]);
      default:         prdata = '0;
    endcase
  end

  // divisor follows the gains; the user must change them only while the block is idle, which it does not enforce
  always_ff @(posedge clk) begin
    den_reg <= DEN_W'(UNITY) + DEN_W'(gain_reg[0]) + DEN_W'(gain_reg[1])
             + DEN_W'(gain_reg[2]);
  end

  // load chain: a stage takes new data when empty or when it moves on
  genvar k;
  generate
    for (k = 1; k <= NST; k++) begin : g_ld
      if (k == NST) begin : g_last
        assign ld[k] = !vld[k] || !out_stall;
      end else begin : g_mid
        assign ld[k] = !vld[k] || ld[k+1];
      end
    end
  endgenerate

  assign in_stall  = !ld[1];
  assign acc       = in_valid && !in_stall;
  assign out_valid = vld[NST];
  assign sample_out = dv_q[Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= acc;
      end
      for (int i = 2; i <= NST; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      samples_seen <= '0;
    end else if (acc) begin
      write_index <= write_index + AW'(1);
      if (samples_seen < SEEN_LIMIT) begin
        samples_seen <= samples_seen + SEEN_W'(1);
      end
    end
  end

  // history read per tap; a tap whose distance wraps to the current slot
  // takes the incoming sample instead of the RAM
  generate
    for (k = 0; k < NUM_TAPS; k++) begin : g_tap
      logic [AW+DLY_W-1:0] back_ext;
      logic [AW-1:0]       back;
      logic [AW-1:0]       rd_addr;

      assign back_ext = {{AW{1'b0}}, delay_reg[k]};
      assign back     = back_ext[AW-1:0];
      assign rd_addr  = write_index - back;

      tte_ram #(
        .WIDTH(SMP_W),
        .DEPTH(HISTORY_DEPTH)
      ) u_ring (
        .clk    (clk),
        .wr_en  (acc),
        .wr_addr(write_index),
        .wr_data(sample_in),
        .rd_en  (acc),
        .rd_addr(rd_addr),
        .rd_data(rd_data[k])
      );

      always_ff @(posedge clk) begin
        if (ld[1]) begin
          s1_act[k] <= samples_seen > {1'b0, delay_reg[k]};
          s1_byp[k] <= (back == '0);
        end
      end

      // inactive taps count as silence, which adds 128 * gain to the
      // offset numerator, the same as a centred zero
      logic [SMP_W-1:0] tap;
      always_comb begin
        if (!s1_act[k]) begin
          tap = SMP_MID;
        end else if (s1_byp[k]) begin
          tap = s1_cur;
        end else begin
          tap = rd_data[k];
        end
      end

      always_ff @(posedge clk) begin
        if (ld[2]) begin
          s2_prod[k] <= PROD_W'(tap) * PROD_W'(gain_reg[k]);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_cur <= sample_in;
    end
    if (ld[2]) begin
      s2_cur <= s1_cur;
    end
    // numerator already offset by 128 * den, so it is never negative and
    // the quotient is the output byte
    if (ld[3]) begin
      dv_rem[0] <= (NUM_W'(s2_cur) << GAIN_FRACTION_BITS) + NUM_W'(s2_prod[0])
                 + NUM_W'(s2_prod[1]) + NUM_W'(s2_prod[2]);
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  generate
    for (k = 1; k <= Q_W; k++) begin : g_div
      logic [NUM_W-1:0] dsh;
      logic             ge;
      logic [Q_W-1:0]   q_prev;
      logic [Q_W-1:0]   q_new;

      assign dsh = NUM_W'(den_reg) << (Q_W - k);
      assign ge  = dv_rem[k-1] >= dsh;

      if (k == 1) begin : g_first
        assign q_prev = '0;
      end else begin : g_next
        assign q_prev = dv_q[k-1];
      end

      always_comb begin
        q_new = q_prev;
        q_new[Q_W-k] = ge;
      end

      always_ff @(posedge clk) begin
        if (ld[3+k]) begin
          dv_q[k] <= q_new;
        end
      end

      if (k < Q_W) begin : g_rem
        always_ff @(posedge clk) begin
          if (ld[3+k]) begin
            dv_rem[k] <= ge ? (dv_rem[k-1] - dsh) : dv_rem[k-1];
          end
        end
      end
    end
  endgenerate

  // input only stalls when every stage holds an item and the output is held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("input stalled with a bubble in the pipeline");

  assert property (@(posedge clk) disable iff (rst)
    acc |=> (write_index == $past(write_index) + AW'(1)) && vld[1])
    else $error("accepted item did not advance the write slot");

  assert property (@(posedge clk) disable iff (rst)
    samples_seen <= SEEN_LIMIT)
    else $error("sample count passed its limit");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(sample_out))
    else $error("held result changed");

endmodule

FILE: src/tte_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and read enable. No dependencies.
module tte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: verif/three_tap_echo_mixer_tb.sv
// Testbench for three_tap_echo_mixer: random and directed sample streams, APB register
// setups, and a scoreboard that predicts every echoed sample. Depends on tte_pkg and the RTL.
`timescale 1ns / 1ps

module three_tap_echo_mixer_tb;
  import tte_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;

  // Predicts each echoed sample from its own history ring and register copy.
  class echo_scoreboard;
    bit [SMP_W-1:0]  history [HISTORY_DEPTH_DEF];
    bit [DLY_W-1:0]  next_slot;
    bit [SEEN_W-1:0] seen_count;
    bit [DLY_W-1:0]  tap_delay [NUM_TAPS];
    bit [GAIN_W-1:0] tap_gain [NUM_TAPS];
    bit [SMP_W-1:0]  echo_q [$];
    int              errors;
    int              checked;

    function new();
      next_slot    = '0;
      seen_count   = '0;
      tap_delay[0] = DELAY_ONE_RST;
      tap_delay[1] = DELAY_TWO_RST;
      tap_delay[2] = DELAY_THREE_RST;
      tap_gain[0]  = GAIN_ONE_RST;
      tap_gain[1]  = GAIN_TWO_RST;
      tap_gain[2]  = GAIN_THREE_RST;
      errors       = 0;
      checked      = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_DELAY_ONE:   tap_delay[0] = value[DLY_W-1:0];
        REG_DELAY_TWO:   tap_delay[1] = value[DLY_W-1:0];
        REG_DELAY_THREE: tap_delay[2] = value[DLY_W-1:0];
        REG_GAIN_ONE:    tap_gain[0]  = value[GAIN_W-1:0];
        REG_GAIN_TWO:    tap_gain[1]  = value[GAIN_W-1:0];
        REG_GAIN_THREE:  tap_gain[2]  = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(reg_index_t idx);
      logic [PDATA_W-1:0] value;
      value = '0;
      case (idx)
        REG_DELAY_ONE:   value = PDATA_W'(tap_delay[0]);
        REG_DELAY_TWO:   value = PDATA_W'(tap_delay[1]);
        REG_DELAY_THREE: value = PDATA_W'(tap_delay[2]);
        REG_GAIN_ONE:    value = PDATA_W'(tap_gain[0]);
        REG_GAIN_TWO:    value = PDATA_W'(tap_gain[1]);
        REG_GAIN_THREE:  value = PDATA_W'(tap_gain[2]);
        default: ;
      endcase
      return value;
    endfunction

    function void predict_echo(logic [SMP_W-1:0] sample);
      int             unity;
      int             acc;
      int             den;
      int             quot;
      bit [DLY_W-1:0] slot;
      unity = 1 << GAIN_FRACTION_BITS_DEF;
      // store first, so the taps see the ring including this sample
      history[next_slot] = sample;
      acc = (int'(sample) - 128) * unity;
      den = unity;
      for (int k = 0; k < NUM_TAPS; k++) begin
        den += int'(tap_gain[k]);
        if (seen_count > SEEN_W'(tap_delay[k])) begin
          slot = next_slot - tap_delay[k];
          acc += (int'(history[slot]) - 128) * int'(tap_gain[k]);
        end
      end
      // floor division: truncation rounds negative quotients up
      quot = acc / den;
      if ((acc % den) != 0 && acc < 0) quot -= 1;
      quot += 128;
      if (quot < 0) quot = 0;
      if (quot > 255) quot = 255;
      echo_q.push_back(SMP_W'(quot));
      next_slot++;
      if (seen_count < SEEN_LIMIT) seen_count++;
    endfunction

    function void check_echo(logic [SMP_W-1:0] got);
      bit [SMP_W-1:0] want;
      if (echo_q.size() == 0) begin
        $error("sample_out: result %0d arrived with nothing pending", got);
        errors++;
        return;
      end
      want = echo_q.pop_front();
      checked++;
      if (got !== want) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SMP_W-1:0]   sample_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SMP_W-1:0]   sample_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  echo_scoreboard sb;
  bit             send_gaps;
  bit             recv_stalls;
  int             stall_left;
  int             idle_cycles;
  int             samples_sent;
  int             settings_count;

  three_tap_echo_mixer u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // note accepted samples and check accepted echoes
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.predict_echo(sample_in);
    if (!rst && out_valid && !out_stall) sb.check_echo(sample_out);
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(7, 40);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!send_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return SMP_MID;
    return SMP_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DLY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DLY_W'($urandom_range(4, 40));
    if (r < 85) return DLY_W'($urandom_range(41, 1100));
    if (r < 95) return DLY_W'($urandom_range(1101, 65534));
    return '1;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return GAIN_W'(256);
    if (r < 25) return GAIN_W'($urandom_range(257, 511));
    return GAIN_W'($urandom_range(0, 256));
  endfunction

  // hold the sample until accepted; valid drops only during a gap
  task automatic send_sample(input logic [SMP_W-1:0] sample, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= sample;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.echo_q.size() != 0);
  endtask

  // psel stays high between back-to-back transfers; apply_settings releases it
  task automatic apb_access(input bit is_write, input reg_index_t idx,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (is_write) sb.write_reg(idx, wdata);
  endtask

  task automatic apply_settings(input bit do_write, input logic [DLY_W-1:0] d1,
                                input logic [DLY_W-1:0] d2, input logic [DLY_W-1:0] d3,
                                input logic [GAIN_W-1:0] g1, input logic [GAIN_W-1:0] g2,
                                input logic [GAIN_W-1:0] g3);
    logic [PDATA_W-1:0] values [6];
    logic [PDATA_W-1:0] rdata;
    reg_index_t         idx;
    values = '{PDATA_W'(d1), PDATA_W'(d2), PDATA_W'(d3), PDATA_W'(g1), PDATA_W'(g2),
               PDATA_W'(g3)};
    if (do_write) begin
      for (int i = 0; i < 6; i++) apb_access(1'b1, reg_index_t'(i), values[i], rdata);
      settings_count++;
    end
    for (int i = 0; i < 6; i++) begin
      idx = reg_index_t'(i);
      apb_access(1'b0, idx, '0, rdata);
      if (rdata !== sb.reg_value(idx)) begin
        $error("%s readback mismatch: expected %0d, actual %0d", idx.name(),
               sb.reg_value(idx), rdata);
        sb.errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [SMP_W-1:0] reset_run [6] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd129, 8'd1};
    logic [SMP_W-1:0] mute_run [5]  = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    logic [SMP_W-1:0] full_run [8]  = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    logic [SMP_W-1:0] loud_run [6]  = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0};
    sb             = new();
    send_gaps      = 1'b0;
    recv_stalls    = 1'b0;
    samples_sent   = 0;
    settings_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset delays are far beyond the first samples: only the dry sample passes
    apply_settings(1'b0, '0, '0, '0, '0, '0, '0);
    foreach (reset_run[i]) send_sample(reset_run[i], 0);
    drain();

    // zero gains: output equals input
    apply_settings(1'b1, 16'd4, 16'd4, 16'd4, 9'd0, 9'd0, 9'd0);
    foreach (mute_run[i]) send_sample(mute_run[i], 0);
    drain();

    // full unity gains on the shortest delays
    apply_settings(1'b1, 16'd4, 16'd5, 16'd6, 9'd256, 9'd256, 9'd256);
    foreach (full_run[i]) send_sample(full_run[i], 0);
    drain();

    // gains above unity on two taps, one tap at the longest delay
    apply_settings(1'b1, 16'd4, 16'hFFFF, 16'd5, 9'd511, 9'd0, 9'd257);
    foreach (loud_run[i]) send_sample(loud_run[i], 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 0) apply_settings(1'b1, '1, '1, '1, 9'd256, 9'd256, 9'd256);
      else apply_settings(1'b1, pick_delay(), pick_delay(), pick_delay(), pick_gain(),
                          pick_gain(), pick_gain());
      send_gaps   = (p % 3 != 0);
      recv_stalls = (p % 4 != 1);
      for (int n = 0; n < 100; n++) begin
        // let the pipeline run dry once in the middle of a stream
        if (p == 5 && n == 50) drain();
        send_sample(pick_sample(), pick_gap());
      end
      drain();
    end

    recv_stalls = 1'b0;
    repeat (30) @(posedge clk);
    $display("Sent %0d samples across %0d tap settings; %0d echoes compared.",
             samples_sent, settings_count, sb.checked);
    if (sb.errors == 0 && sb.echo_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tte_pkg.sv
src/tte_ram.sv
src/three_tap_echo_mixer.sv
verif/three_tap_echo_mixer_tb.sv
